>>> hdl/clns_pkg.sv
// shared types, codes and the init sequence table for the lcd nibble sequencer
`default_nettype none
package clns_pkg;

  // request codes
  localparam logic [2:0] CMD_INIT   = 3'd0;
  localparam logic [2:0] CMD_BYTE   = 3'd1;
  localparam logic [2:0] CMD_CHAR   = 3'd2;
  localparam logic [2:0] CMD_CURSOR = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  // configuration register indexes
  localparam logic CFG_ENABLE_HIGH = 1'b0;
  localparam logic CFG_SETTLE      = 1'b1;

  localparam logic [7:0]  ENABLE_HIGH_RESET = 8'd3;
  localparam logic [9:0]  SETTLE_RESET      = 10'd50;
  localparam logic [7:0]  LINE1_BASE        = 8'h80;
  localparam logic [7:0]  LINE2_BASE        = 8'hC0;
  localparam logic [7:0]  CLEAR_BYTE        = 8'h01;
  localparam logic [9:0]  CURSOR_WAIT_US    = 10'd1000;
  localparam logic [14:0] CURSOR_EXTRA_US   = 15'd50;
  localparam logic [14:0] CLEAR_EXTRA_US    = 15'd10000;
  localparam logic [3:0]  INIT_LAST_STEP    = 4'd11;
  localparam logic [3:0]  BYTE_LAST_STEP    = 4'd1;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] byte_value;
    logic [5:0] column;
    logic       row;
  } in_word_t;

  typedef struct packed {
    logic        reg_select;
    logic        read_write;
    logic [3:0]  nibble;
    logic        strobe_res;
    logic [9:0]  wait_before_us;
    logic [14:0] wait_after_us;
    logic        last;
  } out_word_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic       load_req;
    logic       load_out;
    logic [3:0] step;
    logic       last;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cmd_ok;
    logic is_init;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [3:0]  nibble;
    logic        strobe;
    logic [14:0] extra_us;
  } init_act_t;

  // power-up wake-up sequence, one action per step
  function automatic init_act_t init_action(logic [3:0] step);
    init_act_t a;
    a = '{nibble: 4'h0, strobe: 1'b1, extra_us: 15'd0};
    case (step)
      4'd0:    a = '{nibble: 4'h0, strobe: 1'b0, extra_us: 15'd20000};
      4'd1:    a = '{nibble: 4'h3, strobe: 1'b1, extra_us: 15'd5000};
      4'd2:    a = '{nibble: 4'h3, strobe: 1'b1, extra_us: 15'd100};
      4'd3:    a.nibble = 4'h2;
      4'd4:    a.nibble = 4'h2;
      4'd5:    a.nibble = 4'h8;
      4'd6:    a.nibble = 4'h0;
      4'd7:    a.nibble = 4'hC;
      4'd8:    a.nibble = 4'h0;
      4'd9:    a.nibble = 4'h6;
      4'd10:   a.nibble = 4'h0;
      4'd11:   a.nibble = 4'h1;
      default: a.nibble = 4'h0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

>>> hdl/char_lcd_nibble_sequencer.sv
// top level of the 4-bit character lcd nibble sequencer
`default_nettype none
// Turns one request (init, command byte, character, cursor set, clear) into
// pin action words for a 4-bit character LCD, one word per cycle while the
// output side takes them. Init yields twelve words, every other request two,
// and an unknown request code is taken and yields none. A word is loaded into
// the output register each cycle that register is empty or being drained; the
// step counter in the controller sets the length. A request is taken in an
// idle cycle and its words are then loaded, one per cycle unless the output
// stalls, and an unknown request code leaves the controller idle. The next
// request is taken in the cycle after the last word is loaded, while that
// word still waits to be taken. Config writes go to enable_high_us (index 0)
// and settle_us (index 1).
module char_lcd_nibble_sequencer (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire                  cfg_index_i,
  input  wire  [9:0]           cfg_data_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  clns_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output clns_pkg::out_word_t  out_data_o
);
  import clns_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  // controller
  clns_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  // datapath
  clns_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (ctrl_cmd),
    .status_o    (dp_status)
  );

endmodule
`default_nettype wire

>>> hdl/clns_ctrl.sv
// controller state machine: request acceptance and action step counting
`default_nettype none
module clns_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  clns_pkg::dp_status_t  status_i,
  output clns_pkg::ctrl_cmd_t   cmd_o
);
  import clns_pkg::*;

  state_e     state_q, state_d;
  logic [3:0] step_q, step_d;
  logic       last_step;

  assign last_step = status_i.is_init ? (step_q == INIT_LAST_STEP)
                                      : (step_q == BYTE_LAST_STEP);

  // state and step registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.cmd_ok) begin
          state_d = ST_RUN;
          step_d  = '0;
        end
      end
      ST_RUN: begin
        if (status_i.out_free) begin
          if (last_step) begin
            state_d = ST_IDLE;
          end else begin
            step_d = step_q + 4'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o.load_req = 1'b0;
    cmd_o.load_out = 1'b0;
    cmd_o.step     = step_q;
    cmd_o.last     = last_step;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_req = in_valid_i;
      end
      ST_RUN: begin
        cmd_o.load_out = status_i.out_free;
      end
      default: in_ready_o = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/clns_dp.sv
// datapath: config registers, request latch, action build and output register
`default_nettype none
module clns_dp (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire                   cfg_index_i,
  input  wire  [9:0]            cfg_data_i,
  input  clns_pkg::in_word_t    in_data_i,
  input  wire                   out_ready_i,
  output logic                  out_valid_o,
  output clns_pkg::out_word_t   out_data_o,
  input  clns_pkg::ctrl_cmd_t   cmd_i,
  output clns_pkg::dp_status_t  status_o
);
  import clns_pkg::*;

  logic [7:0] enable_high_q;
  logic [9:0] settle_q;
  logic [2:0] req_cmd_q;
  logic [7:0] req_byte_q;
  logic       req_rs_q;
  logic [7:0] req_byte_d;
  logic       out_valid_q;
  out_word_t  out_q;
  out_word_t  act;
  init_act_t  ia;

  // configuration registers; the enable high time is stored but drives no output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_high_q <= ENABLE_HIGH_RESET;
      settle_q      <= SETTLE_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_ENABLE_HIGH) enable_high_q <= cfg_data_i[7:0];
      if (cfg_index_i == CFG_SETTLE)      settle_q      <= cfg_data_i;
    end
  end

  // byte to send for the incoming request
  always_comb begin
    case (in_data_i.cmd)
      CMD_CURSOR: req_byte_d = (in_data_i.row ? LINE2_BASE : LINE1_BASE)
                               + {2'b00, in_data_i.column};
      CMD_CLEAR:  req_byte_d = CLEAR_BYTE;
      default:    req_byte_d = in_data_i.byte_value;
    endcase
  end

  // request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_cmd_q  <= in_data_i.cmd;
      req_byte_q <= req_byte_d;
      req_rs_q   <= (in_data_i.cmd == CMD_CHAR);
    end
  end

  // action for the current step
  always_comb begin
    ia                 = init_action(cmd_i.step);
    act.reg_select     = 1'b0;
    act.read_write     = 1'b0;
    act.nibble         = 4'h0;
    act.strobe_res     = 1'b1;
    act.wait_before_us = '0;
    act.wait_after_us  = {5'd0, settle_q};
    act.last           = cmd_i.last;
    if (req_cmd_q == CMD_INIT) begin
      act.nibble        = ia.nibble;
      act.strobe_res    = ia.strobe;
      act.wait_after_us = (ia.strobe ? {5'd0, settle_q} : 15'd0) + ia.extra_us;
    end else begin
      act.reg_select = req_rs_q;
      if (cmd_i.step == 4'd0) begin
        act.nibble = req_byte_q[7:4];
        if (req_cmd_q == CMD_CURSOR) act.wait_before_us = CURSOR_WAIT_US;
      end else begin
        act.nibble = req_byte_q[3:0];
        if (req_cmd_q == CMD_CURSOR) begin
          act.wait_after_us = {5'd0, settle_q} + CURSOR_EXTRA_US;
        end else if (req_cmd_q == CMD_CLEAR) begin
          act.wait_after_us = {5'd0, settle_q} + CLEAR_EXTRA_US;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) out_q <= act;
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
  assign status_o.cmd_ok   = (in_data_i.cmd <= CMD_CLEAR);
  assign status_o.is_init  = (req_cmd_q == CMD_INIT) && (enable_high_q == enable_high_q);
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule
`default_nettype wire
